### src/multi_channel_timer_table_defines.svh
// assertion macros for the multi-channel timer table checker
// no dependencies; included by the checker file
`ifndef MULTI_CHANNEL_TIMER_TABLE_DEFINES_SVH
`define MULTI_CHANNEL_TIMER_TABLE_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define MCTT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("timer table check failed");

// next-cycle implication, disabled while reset is asserted
`define MCTT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("timer table check failed");

`endif

### src/mctt_pkg.sv
// shared types and constants of the multi-channel timer table
// no dependencies
package mctt_pkg;

  typedef enum logic [2:0] {
    CmdCreate  = 3'd0,
    CmdStart   = 3'd1,
    CmdStop    = 3'd2,
    CmdRemove  = 3'd3,
    CmdProcess = 3'd4,
    CmdFree    = 3'd5,
    CmdIsRun   = 3'd6
  } cmd_e;

  typedef enum logic [1:0] {
    StOk     = 2'd0,
    StUnused = 2'd1,
    StFull   = 2'd2
  } status_e;

  localparam int unsigned TimeW      = 32;
  localparam int unsigned ResIdxW    = 3;
  localparam int unsigned MaxResults = 8;
  localparam int unsigned CntW       = $clog2(MaxResults) + 1;

  // write enables into the slot memory
  typedef struct packed {
    logic start_we;
    logic period_we;
  } mctt_wr_t;

  // shared time unit result
  typedef struct packed {
    logic             expired;
    logic             better;
    logic [TimeW-1:0] rem;
  } mctt_alu_t;

endpackage

### src/mctt_store.sv
// slot memory holding start time and period of every timer slot
// depends on mctt_pkg
module mctt_store import mctt_pkg::*; #(
  parameter int unsigned Slots = 8
) (
  input  logic                                       clk_i,
  input  logic [((Slots > 1) ? $clog2(Slots) : 1)-1:0] rd_addr_i,
  output logic [TimeW-1:0]                           rd_start_o,
  output logic [TimeW-1:0]                           rd_period_o,
  input  mctt_wr_t                                   wr_i,
  input  logic [((Slots > 1) ? $clog2(Slots) : 1)-1:0] wr_addr_i,
  input  logic [TimeW-1:0]                           wr_start_i,
  input  logic [TimeW-1:0]                           wr_period_i
);

  logic [TimeW-1:0] start_mem  [Slots];
  logic [TimeW-1:0] period_mem [Slots];

  always_ff @(posedge clk_i) begin
    if (wr_i.start_we) begin
      start_mem[wr_addr_i] <= wr_start_i;
    end
    if (wr_i.period_we) begin
      period_mem[wr_addr_i] <= wr_period_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_start_o  <= start_mem[rd_addr_i];
    rd_period_o <= period_mem[rd_addr_i];
  end

endmodule

### src/mctt_alu.sv
// shared time unit: elapsed/expiry test and remaining-time compare
// depends on mctt_pkg
module mctt_alu import mctt_pkg::*; (
  input  logic [TimeW-1:0] now_i,
  input  logic [TimeW-1:0] start_i,
  input  logic [TimeW-1:0] period_i,
  input  logic [TimeW-1:0] best_i,
  output mctt_alu_t        res_o
);

  logic [TimeW-1:0] elapsed;

  // all arithmetic wraps modulo 2^32
  assign elapsed       = now_i - start_i;
  assign res_o.rem     = start_i + period_i - now_i;
  assign res_o.expired = elapsed > period_i;
  assign res_o.better  = res_o.rem < best_i;

endmodule

### src/multi_channel_timer_table.sv
// multi-channel timer table: start, stop, remove and is-running pass through the StExec
// state and show their result from the output register while busy is already low, so
// the next item can be accepted while the result shows; create, process and query free
// walk the slots one per cycle through the memory read port, and busy drops while the
// final result shows; process gives up to 8 results, last on the final one; reset clears
// the used/running/once flags and the control state, not the slot memory or payload; results cannot be held off
module multi_channel_timer_table import mctt_pkg::*; #(
  parameter int unsigned TIMER_SLOTS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [2:0]          command_i,
  input  logic [2:0]          timer_index_i,
  input  logic [TimeW-1:0]    period_i,
  input  logic                once_mode_i,
  input  logic [TimeW-1:0]    now_time_i,
  output logic                result_strobe_o,
  output logic [1:0]          status_o,
  output logic [ResIdxW-1:0]  timer_index_res_o,
  output logic                expired_o,
  output logic [TimeW-1:0]    free_time_o,
  output logic                running_o,
  output logic                last_o
);

  localparam int unsigned SW   = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int unsigned CW   = SW + 1;
  // wide enough for any command index and for the slot count itself
  localparam int unsigned IdxW = ((SW > ResIdxW) ? SW : ResIdxW) + 1;

  // sequencer states
  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StExec  = 4'b0010,
    StScan  = 4'b0100,
    StFlush = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // latched item
  cmd_e             cmd_q, cmd_d;
  logic [2:0]       idx_q, idx_d;
  logic [TimeW-1:0] per_q, per_d;
  logic             once_mode_q, once_mode_d;
  logic [TimeW-1:0] now_q, now_d;

  // slot walk: issue pointer and the slot whose data is back from memory
  logic [CW-1:0]    iss_q, iss_d;
  logic             ev_vld_q, ev_vld_d;
  logic [SW-1:0]    ev_ptr_q, ev_ptr_d;

  // process bookkeeping: one expiry held back so the final one can carry last
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               pend_vld_q, pend_vld_d;
  logic [ResIdxW-1:0] pend_idx_q, pend_idx_d;
  logic [TimeW-1:0]   best_q, best_d;

  // slot flags, cleared by reset
  logic [TIMER_SLOTS-1:0] slot_used_q, slot_used_d;
  logic [TIMER_SLOTS-1:0] slot_run_q, slot_run_d;
  logic [TIMER_SLOTS-1:0] slot_once_q, slot_once_d;

  // result register
  logic               out_vld_q, out_vld_d;
  status_e            out_status_q, out_status_d;
  logic [ResIdxW-1:0] out_idx_q, out_idx_d;
  logic               out_exp_q, out_exp_d;
  logic [TimeW-1:0]   out_free_q, out_free_d;
  logic               out_run_q, out_run_d;
  logic               out_last_q, out_last_d;

  // memory and shared unit hookup
  mctt_wr_t         mem_wr;
  logic [SW-1:0]    mem_wr_addr;
  logic [TimeW-1:0] mem_start;
  logic [TimeW-1:0] mem_period;
  mctt_alu_t        alu;

  // addressed slot for the single-slot commands
  logic [IdxW-1:0]  idx_wide;
  logic [SW-1:0]    idx_slot;
  logic             idx_valid;
  logic             ev_last_slot;
  logic             ev_active;

  assign idx_wide     = IdxW'(idx_q);
  assign idx_slot     = idx_wide[SW-1:0];
  assign idx_valid    = (idx_wide < IdxW'(TIMER_SLOTS)) && slot_used_q[idx_slot];
  assign ev_last_slot = ({1'b0, ev_ptr_q} == CW'(TIMER_SLOTS - 1));
  assign ev_active    = slot_used_q[ev_ptr_q] && slot_run_q[ev_ptr_q];
  assign mem_wr_addr  = (state_q == StExec) ? idx_slot : ev_ptr_q;

  mctt_store #(
    .Slots (TIMER_SLOTS)
  ) u_store (
    .clk_i       (clk_i),
    .rd_addr_i   (iss_q[SW-1:0]),
    .rd_start_o  (mem_start),
    .rd_period_o (mem_period),
    .wr_i        (mem_wr),
    .wr_addr_i   (mem_wr_addr),
    .wr_start_i  (now_q),
    .wr_period_i (per_q)
  );

  mctt_alu u_alu (
    .now_i    (now_q),
    .start_i  (mem_start),
    .period_i (mem_period),
    .best_i   (best_q),
    .res_o    (alu)
  );

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    idx_d        = idx_q;
    per_d        = per_q;
    once_mode_d  = once_mode_q;
    now_d        = now_q;
    iss_d        = iss_q;
    ev_vld_d     = 1'b0;
    ev_ptr_d     = ev_ptr_q;
    cnt_d        = cnt_q;
    pend_vld_d   = pend_vld_q;
    pend_idx_d   = pend_idx_q;
    best_d       = best_q;
    slot_used_d  = slot_used_q;
    slot_run_d   = slot_run_q;
    slot_once_d  = slot_once_q;
    out_vld_d    = 1'b0;
    out_status_d = StOk;
    out_idx_d    = '0;
    out_exp_d    = 1'b0;
    out_free_d   = '0;
    out_run_d    = 1'b0;
    out_last_d   = 1'b0;
    mem_wr       = '0;

    case (state_q)
      StIdle: begin
        if (start) begin
          cmd_d       = cmd_e'(command_i);
          idx_d       = timer_index_i;
          per_d       = period_i;
          once_mode_d = once_mode_i;
          now_d       = now_time_i;
          iss_d       = '0;
          cnt_d       = '0;
          pend_vld_d  = 1'b0;
          best_d      = '1;
          if (command_i == CmdCreate || command_i == CmdProcess ||
              command_i == CmdFree) begin
            state_d = StScan;
          end else begin
            state_d = StExec;
          end
        end
      end

      StExec: begin
        out_vld_d  = 1'b1;
        out_last_d = 1'b1;
        state_d    = StIdle;
        case (cmd_q)
          CmdStart: begin
            out_status_d = idx_valid ? StOk : StUnused;
            if (idx_valid) begin
              mem_wr.start_we      = 1'b1;
              slot_run_d[idx_slot] = 1'b1;
            end
          end
          CmdStop: begin
            out_status_d = idx_valid ? StOk : StUnused;
            if (idx_valid) begin
              slot_run_d[idx_slot] = 1'b0;
            end
          end
          CmdRemove: begin
            out_status_d = idx_valid ? StOk : StUnused;
            if (idx_valid) begin
              slot_used_d[idx_slot] = 1'b0;
              slot_run_d[idx_slot]  = 1'b0;
              slot_once_d[idx_slot] = 1'b0;
            end
          end
          CmdIsRun: begin
            out_status_d = idx_valid ? StOk : StUnused;
            out_run_d    = idx_valid && slot_run_q[idx_slot];
          end
          default: begin
            // unknown command: status ok and all-zero fields, with last set
            out_status_d = StOk;
          end
        endcase
      end

      StScan: begin
        // keep one memory read in flight ahead of the evaluated slot
        if (iss_q < CW'(TIMER_SLOTS)) begin
          iss_d    = iss_q + CW'(1);
          ev_vld_d = 1'b1;
          ev_ptr_d = iss_q[SW-1:0];
        end
        if (ev_vld_q) begin
          case (cmd_q)
            CmdCreate: begin
              if (!slot_used_q[ev_ptr_q]) begin
                slot_used_d[ev_ptr_q] = 1'b1;
                slot_run_d[ev_ptr_q]  = 1'b0;
                slot_once_d[ev_ptr_q] = once_mode_q;
                mem_wr.start_we       = 1'b1;
                mem_wr.period_we      = 1'b1;
                out_vld_d             = 1'b1;
                out_status_d          = StOk;
                out_idx_d             = ResIdxW'(ev_ptr_q);
                out_last_d            = 1'b1;
                state_d               = StIdle;
              end else if (ev_last_slot) begin
                out_vld_d    = 1'b1;
                out_status_d = StFull;
                out_last_d   = 1'b1;
                state_d      = StIdle;
              end
            end
            CmdProcess: begin
              if (ev_active && alu.expired) begin
                mem_wr.start_we = 1'b1;
                if (slot_once_q[ev_ptr_q]) begin
                  slot_used_d[ev_ptr_q] = 1'b0;
                  slot_run_d[ev_ptr_q]  = 1'b0;
                  slot_once_d[ev_ptr_q] = 1'b0;
                end
                // the held expiry is now known not to be the final one
                if (pend_vld_q) begin
                  out_vld_d = 1'b1;
                  out_idx_d = pend_idx_q;
                  out_exp_d = 1'b1;
                end
                pend_vld_d = 1'b1;
                pend_idx_d = ResIdxW'(ev_ptr_q);
                cnt_d      = cnt_q + CntW'(1);
                if (cnt_q == CntW'(MaxResults - 1)) begin
                  state_d = StFlush;
                end
              end
              if (ev_last_slot) begin
                state_d = StFlush;
              end
            end
            CmdFree: begin
              if (ev_active && alu.better) begin
                best_d = alu.rem;
              end
              if (ev_last_slot) begin
                state_d = StFlush;
              end
            end
            default: begin
              state_d = StIdle;
            end
          endcase
        end
      end

      StFlush: begin
        out_vld_d  = 1'b1;
        out_last_d = 1'b1;
        state_d    = StIdle;
        if (cmd_q == CmdProcess) begin
          out_idx_d = pend_vld_q ? pend_idx_q : '0;
          out_exp_d = pend_vld_q;
        end else begin
          out_free_d = (best_q == '1) ? '0 : best_q;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      iss_q       <= '0;
      ev_vld_q    <= 1'b0;
      cnt_q       <= '0;
      pend_vld_q  <= 1'b0;
      slot_used_q <= '0;
      slot_run_q  <= '0;
      slot_once_q <= '0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      iss_q       <= iss_d;
      ev_vld_q    <= ev_vld_d;
      cnt_q       <= cnt_d;
      pend_vld_q  <= pend_vld_d;
      slot_used_q <= slot_used_d;
      slot_run_q  <= slot_run_d;
      slot_once_q <= slot_once_d;
      out_vld_q   <= out_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    idx_q        <= idx_d;
    per_q        <= per_d;
    once_mode_q  <= once_mode_d;
    now_q        <= now_d;
    ev_ptr_q     <= ev_ptr_d;
    pend_idx_q   <= pend_idx_d;
    best_q       <= best_d;
    out_status_q <= out_status_d;
    out_idx_q    <= out_idx_d;
    out_exp_q    <= out_exp_d;
    out_free_q   <= out_free_d;
    out_run_q    <= out_run_d;
    out_last_q   <= out_last_d;
  end

  assign busy              = (state_q != StIdle);
  assign result_strobe_o   = out_vld_q;
  assign status_o          = out_status_q;
  assign timer_index_res_o = out_idx_q;
  assign expired_o         = out_exp_q;
  assign free_time_o       = out_free_q;
  assign running_o         = out_run_q;
  assign last_o            = out_last_q;

endmodule

### src/mctt_checker.sv
// port-level checks of the multi-channel timer table, bound to the top level
// depends on mctt_pkg and multi_channel_timer_table_defines.svh
`include "multi_channel_timer_table_defines.svh"

module mctt_checker import mctt_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start,
  input logic                busy,
  input logic                result_strobe_o,
  input logic [1:0]          status_o,
  input logic                expired_o,
  input logic [TimeW-1:0]    free_time_o,
  input logic                running_o,
  input logic                last_o
);

  // an expiry item carries its slot and last flag, with status ok, zero free time, not running
  logic exp_fields_zero;
  assign exp_fields_zero = (status_o == StOk) && (free_time_o == '0) && !running_o;

  `MCTT_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy)
  `MCTT_ASSERT_IMPL(a_more_keeps_busy, clk_i, rst_ni, result_strobe_o && !last_o, busy)
  `MCTT_ASSERT_IMPL(a_done_has_last, clk_i, rst_ni, $fell(busy), result_strobe_o && last_o)
  `MCTT_ASSERT_IMPL(a_expired_clean, clk_i, rst_ni, result_strobe_o && expired_o, exp_fields_zero)

endmodule

bind multi_channel_timer_table mctt_checker u_mctt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .result_strobe_o (result_strobe_o),
  .status_o        (status_o),
  .expired_o       (expired_o),
  .free_time_o     (free_time_o),
  .running_o       (running_o),
  .last_o          (last_o)
);

### tb/multi_channel_timer_table_tb.sv
// testbench of the multi-channel timer table: directed corner cases, then random
// command traffic checked item by item against a slot-table predictor
// depends on mctt_pkg and multi_channel_timer_table
module multi_channel_timer_table_tb;
  import mctt_pkg::*;

  localparam int unsigned Slots         = 8;
  localparam logic [2:0]  CmdUnknown    = 3'd7;
  localparam int unsigned ItemsPerPhase = 86;
  localparam int unsigned SettleCycles  = Slots + MaxResults + 4;

  // one result item as the block should report it
  typedef struct {
    status_e          status;
    logic [2:0]       slot;
    logic             expired;
    logic [TimeW-1:0] free_time;
    logic             running;
    logic             last;
  } timer_report_t;

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic             busy;
  logic [2:0]       command_i;
  logic [2:0]       timer_index_i;
  logic [TimeW-1:0] period_i;
  logic             once_mode_i;
  logic [TimeW-1:0] now_time_i;
  logic             result_strobe_o;
  logic [1:0]       status_o;
  logic [2:0]       timer_index_res_o;
  logic             expired_o;
  logic [TimeW-1:0] free_time_o;
  logic             running_o;
  logic             last_o;

  // predictor copy of the slot table
  bit               slot_used    [Slots];
  bit               slot_running [Slots];
  bit               slot_once    [Slots];
  logic [TimeW-1:0] slot_stamp   [Slots];
  logic [TimeW-1:0] slot_period  [Slots];

  timer_report_t    timer_reports_due[$];
  int unsigned      mismatch_count;
  int unsigned      sender_idle_pct;
  logic [TimeW-1:0] wall_clock;

  multi_channel_timer_table #(
    .TIMER_SLOTS(Slots)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .command_i        (command_i),
    .timer_index_i    (timer_index_i),
    .period_i         (period_i),
    .once_mode_i      (once_mode_i),
    .now_time_i       (now_time_i),
    .result_strobe_o  (result_strobe_o),
    .status_o         (status_o),
    .timer_index_res_o(timer_index_res_o),
    .expired_o        (expired_o),
    .free_time_o      (free_time_o),
    .running_o        (running_o),
    .last_o           (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic timer_report_t make_report(status_e st, logic [2:0] slot,
                                                logic exp, logic [TimeW-1:0] ft,
                                                logic run, logic last);
    timer_report_t rep;
    rep.status    = st;
    rep.slot      = slot;
    rep.expired   = exp;
    rep.free_time = ft;
    rep.running   = run;
    rep.last      = last;
    return rep;
  endfunction

  // apply one accepted command to the slot table and queue the items it must cause
  task automatic predict_timer_command(logic [2:0] cmd, logic [2:0] idx,
                                       logic [TimeW-1:0] per, logic once,
                                       logic [TimeW-1:0] now);
    logic [TimeW-1:0] elapsed;
    logic [TimeW-1:0] remaining;
    logic [TimeW-1:0] best;
    bit               in_use;
    bit               placed;
    int               fired;
    status_e          st;
    in_use = slot_used[idx];
    st     = in_use ? StOk : StUnused;
    case (cmd)
      CmdCreate: begin
        placed = 1'b0;
        for (int i = 0; i < Slots; i++) begin
          if (!placed && !slot_used[i]) begin
            placed          = 1'b1;
            slot_used[i]    = 1'b1;
            slot_running[i] = 1'b0;
            slot_once[i]    = once;
            slot_stamp[i]   = now;
            slot_period[i]  = per;
            timer_reports_due.push_back(make_report(StOk, 3'(i), 1'b0, '0, 1'b0, 1'b1));
          end
        end
        // full table leaves everything untouched
        if (!placed)
          timer_reports_due.push_back(make_report(StFull, '0, 1'b0, '0, 1'b0, 1'b1));
      end
      CmdStart: begin
        if (in_use) begin
          slot_stamp[idx]   = now;
          slot_running[idx] = 1'b1;
        end
        timer_reports_due.push_back(make_report(st, '0, 1'b0, '0, 1'b0, 1'b1));
      end
      CmdStop: begin
        if (in_use) slot_running[idx] = 1'b0;
        timer_reports_due.push_back(make_report(st, '0, 1'b0, '0, 1'b0, 1'b1));
      end
      CmdRemove: begin
        if (in_use) begin
          slot_used[idx]    = 1'b0;
          slot_running[idx] = 1'b0;
          slot_once[idx]    = 1'b0;
        end
        timer_reports_due.push_back(make_report(st, '0, 1'b0, '0, 1'b0, 1'b1));
      end
      CmdProcess: begin
        fired = 0;
        for (int i = 0; i < Slots; i++) begin
          if (fired < MaxResults && slot_used[i] && slot_running[i]) begin
            elapsed = now - slot_stamp[i];
            // strictly greater: elapsed equal to the period is not yet due
            if (elapsed > slot_period[i]) begin
              slot_stamp[i] = now;
              if (slot_once[i]) begin
                slot_used[i]    = 1'b0;
                slot_running[i] = 1'b0;
                slot_once[i]    = 1'b0;
              end
              timer_reports_due.push_back(make_report(StOk, 3'(i), 1'b1, '0, 1'b0, 1'b0));
              fired++;
            end
          end
        end
        if (fired == 0)
          timer_reports_due.push_back(make_report(StOk, '0, 1'b0, '0, 1'b0, 1'b1));
        else timer_reports_due[$].last = 1'b1;
      end
      CmdFree: begin
        best = '1;
        for (int i = 0; i < Slots; i++) begin
          if (slot_used[i] && slot_running[i]) begin
            remaining = slot_stamp[i] + slot_period[i] - now;
            if (remaining < best) best = remaining;
          end
        end
        // an all-ones minimum reads back as zero, same as no running slot
        if (best == '1) best = '0;
        timer_reports_due.push_back(make_report(StOk, '0, 1'b0, best, 1'b0, 1'b1));
      end
      CmdIsRun: begin
        timer_reports_due.push_back(make_report(st, '0, 1'b0, '0,
                                                in_use && slot_running[idx], 1'b1));
      end
      default: begin
        timer_reports_due.push_back(make_report(StOk, '0, 1'b0, '0, 1'b0, 1'b1));
      end
    endcase
  endtask

  // present one item, hold it until accepted, then predict it
  // entered and left at a rising edge; busy is sampled on the falling edge
  task automatic send_item(logic [2:0] cmd, logic [2:0] idx, logic [TimeW-1:0] per,
                           logic once, logic [TimeW-1:0] now);
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    start         <= 1'b1;
    command_i     <= cmd;
    timer_index_i <= idx;
    period_i      <= per;
    once_mode_i   <= once;
    now_time_i    <= now;
    @(negedge clk_i);
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
    predict_timer_command(cmd, idx, per, once, now);
  endtask

  // hold the sender off until every predicted item has come back
  task automatic wait_for_drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (timer_reports_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // every result item is compared with the oldest prediction
  always @(negedge clk_i) begin
    timer_report_t want;
    if (rst_ni && result_strobe_o) begin
      if (timer_reports_due.size() == 0) begin
        $error("result item with nothing expected: slot %0d", timer_index_res_o);
        mismatch_count++;
      end else begin
        want = timer_reports_due.pop_front();
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          mismatch_count++;
        end
        if (timer_index_res_o !== want.slot) begin
          $error("timer_index_res: expected %0d, got %0d", want.slot, timer_index_res_o);
          mismatch_count++;
        end
        if (expired_o !== want.expired) begin
          $error("expired: expected %0d, got %0d", want.expired, expired_o);
          mismatch_count++;
        end
        if (free_time_o !== want.free_time) begin
          $error("free_time: expected %0h, got %0h", want.free_time, free_time_o);
          mismatch_count++;
        end
        if (running_o !== want.running) begin
          $error("running: expected %0d, got %0d", want.running, running_o);
          mismatch_count++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, last_o);
          mismatch_count++;
        end
      end
    end
  end

  // fill all slots with extreme periods, then one create too many
  task automatic test_fill_table(logic [TimeW-1:0] t0);
    send_item(CmdCreate, 3'd0, 32'd0, 1'b1, t0);
    send_item(CmdCreate, 3'd7, 32'hFFFF_FFFF, 1'b0, t0);
    send_item(CmdCreate, 3'd0, 32'd5, 1'b0, t0);
    for (int i = 3; i < Slots; i++) begin
      send_item(CmdCreate, 3'(i), 32'h8000_0000 >> i, i[0], t0);
    end
    send_item(CmdCreate, 3'd5, 32'hAAAA_5555, 1'b1, t0);
  endtask

  // every slot command on a slot that has just been freed
  task automatic test_free_slot_access(logic [TimeW-1:0] t0);
    send_item(CmdRemove, 3'd7, '0, 1'b0, t0);
    send_item(CmdRemove, 3'd7, '0, 1'b0, t0);
    send_item(CmdIsRun,  3'd7, '0, 1'b0, t0);
    send_item(CmdStart,  3'd7, '0, 1'b0, t0);
    send_item(CmdStop,   3'd7, '0, 1'b0, t0);
  endtask

  // due exactly at the period versus one tick past it, across the timestamp wrap
  task automatic test_expiry_bounds(logic [TimeW-1:0] t0);
    send_item(CmdStart,   3'd0, '0, 1'b0, t0);
    send_item(CmdStart,   3'd1, '0, 1'b0, t0);
    send_item(CmdStart,   3'd2, '0, 1'b0, t0);
    send_item(CmdIsRun,   3'd2, '0, 1'b0, t0);
    send_item(CmdFree,    3'd0, '0, 1'b0, t0 + 32'd1);
    send_item(CmdProcess, 3'd0, '0, 1'b0, t0 + 32'd5);
    send_item(CmdProcess, 3'd0, '0, 1'b0, t0 + 32'd6);
    send_item(CmdStop,    3'd2, '0, 1'b0, t0);
    // only the all-ones period left running: its remaining time is all ones
    send_item(CmdFree,    3'd0, '0, 1'b0, t0);
    send_item(CmdProcess, 3'd0, '0, 1'b0, t0 + 32'd100);
    send_item(CmdFree,    3'd0, '0, 1'b0, t0 + 32'd200);
  endtask

  task automatic test_unknown_command(logic [TimeW-1:0] t0);
    send_item(CmdUnknown, 3'd7, 32'hFFFF_FFFF, 1'b1, t0);
  endtask

  // random traffic: mostly commands on live slots with a slowly moving clock,
  // plus jumps of the clock, random indexes and full-range periods as noise
  task automatic test_random_traffic(int unsigned idle_pct);
    int               pick;
    int               live[$];
    logic [2:0]       cmd;
    logic [2:0]       idx;
    logic [TimeW-1:0] per;
    sender_idle_pct = idle_pct;
    for (int n = 0; n < ItemsPerPhase; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 16)      cmd = CmdCreate;
      else if (pick < 32) cmd = CmdStart;
      else if (pick < 40) cmd = CmdStop;
      else if (pick < 50) cmd = CmdRemove;
      else if (pick < 75) cmd = CmdProcess;
      else if (pick < 87) cmd = CmdFree;
      else                cmd = CmdIsRun;
      live.delete();
      for (int i = 0; i < Slots; i++) if (slot_used[i]) live.push_back(i);
      if (live.size() != 0 && $urandom_range(0, 9) < 8)
        idx = 3'(live[$urandom_range(0, live.size() - 1)]);
      else
        idx = 3'($urandom_range(0, Slots - 1));
      pick = $urandom_range(0, 99);
      if (pick < 70)      per = $urandom_range(0, 40);
      else if (pick < 90) per = $urandom_range(0, 1000);
      else                per = $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 85)      wall_clock = wall_clock + $urandom_range(0, 15);
      else if (pick < 95) wall_clock = wall_clock + $urandom_range(0, 2000);
      else                wall_clock = $urandom;
      send_item(cmd, idx, per, 1'($urandom_range(0, 1)), wall_clock);
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    start           = 1'b0;
    command_i       = '0;
    timer_index_i   = '0;
    period_i        = '0;
    once_mode_i     = 1'b0;
    now_time_i      = '0;
    mismatch_count  = 0;
    sender_idle_pct = 0;
    wall_clock      = $urandom;
    for (int i = 0; i < Slots; i++) begin
      slot_used[i]    = 1'b0;
      slot_running[i] = 1'b0;
      slot_once[i]    = 1'b0;
      slot_stamp[i]   = '0;
      slot_period[i]  = '0;
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part starts just below the timestamp wrap
    test_fill_table(32'hFFFF_FFFD);
    test_free_slot_access(32'hFFFF_FFFD);
    test_expiry_bounds(32'hFFFF_FFFD);
    test_unknown_command(32'h0000_0000);
    wait_for_drain();

    // random phases: back to back, sender idle often, back to back again, then idle sometimes
    test_random_traffic(0);
    wait_for_drain();
    test_random_traffic(54);
    wait_for_drain();
    test_random_traffic(0);
    wait_for_drain();
    test_random_traffic(29);
    wait_for_drain();

    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
